>>> src/lruilm_pkg.sv
package lruilm_pkg;

   // Default pool size and list head entry.
   localparam int LRUILM_ENTRIES    = 1024;
   localparam int LRUILM_ROOT_INDEX = 0;

   // Field widths of the item ports.
   localparam int MODE_W  = 3;
   localparam int INDEX_W = 10;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_ADD_HEAD  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD_TAIL  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MOVE_HEAD = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MOVE_TAIL = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd4;

   // Phase of the sequencer, as seen by the link datapath.
   typedef struct packed {
      logic       clearing;
      logic       evaluating;
      logic       writing;
      logic [1:0] slot;
      logic       finishing;
   } phase_type;

endpackage

>>> src/lru_index_list_manager.sv
// An accepted item passes the link read, S_EVAL, for an applied one the write
// states S_WR0 to S_WR2 on the link memories, and S_DONE, which loads rsp_valid.
// One item at a time: no new item is taken until its result has been loaded.
// Reset is synchronous; afterwards a clearing pass writes every link entry with its
// own index, and no item is accepted until it completes.
module lru_index_list_manager
   import lruilm_pkg::*;
#(
   parameter int ENTRIES    = LRUILM_ENTRIES,
   parameter int ROOT_INDEX = LRUILM_ROOT_INDEX
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [INDEX_W-1:0] req_entry_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_applied,
   output logic               rsp_was_linked,
   output logic               rsp_list_empty,
   output logic [INDEX_W-1:0] rsp_most_recent,
   output logic [INDEX_W-1:0] rsp_least_recent
);

   localparam int LINK_W = $clog2(ENTRIES);
   localparam logic [LINK_W-1:0] ROOT = LINK_W'(ROOT_INDEX);
   localparam logic [LINK_W-1:0] LAST = LINK_W'(ENTRIES - 1);

   phase_type phase;
   logic      rsp_free;
   logic      accept;

   logic [LINK_W-1:0] clr_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [LINK_W-1:0] n_ff;
   logic              in_range_ff;
   logic [LINK_W-1:0] p_ff;
   logic [LINK_W-1:0] x_ff;
   logic [LINK_W-1:0] e_ff;
   logic              applied_ff;
   logic              linked_ff;
   logic [LINK_W-1:0] head_ff;
   logic [LINK_W-1:0] tail_ff;

   logic [LINK_W-1:0] next_rd;
   logic [LINK_W-1:0] prev_rd;

   logic              nw_en;
   logic [LINK_W-1:0] nw_addr;
   logic [LINK_W-1:0] nw_data;
   logic              pw_en;
   logic [LINK_W-1:0] pw_addr;
   logic [LINK_W-1:0] pw_data;

   logic              applied_in;
   logic              linked_in;
   logic [LINK_W-1:0] e_in;

   logic              rsp_valid_ff;
   logic              rsp_applied_ff;
   logic              rsp_was_linked_ff;
   logic              rsp_list_empty_ff;
   logic [INDEX_W-1:0] rsp_most_recent_ff;
   logic [INDEX_W-1:0] rsp_least_recent_ff;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   lruilm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .clear_last (clr_ff == LAST),
      .apply      (applied_in),
      .rsp_free   (rsp_free),
      .req_stall  (req_stall),
      .phase      (phase)
   );

   lruilm_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_next_ram (
      .clock   (clock),
      .wr_en   (nw_en),
      .wr_addr (nw_addr),
      .wr_data (nw_data),
      .rd_en   (accept),
      .rd_addr (LINK_W'(req_entry_index)),
      .rd_data (next_rd)
   );

   lruilm_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pw_en),
      .wr_addr (pw_addr),
      .wr_data (pw_data),
      .rd_en   (accept),
      .rd_addr (LINK_W'(req_entry_index)),
      .rd_data (prev_rd)
   );

   // Guards, evaluated on the links read for the entry.
   always_comb begin
      logic not_root;
      logic unlinked;
      logic in_list;
      not_root = (n_ff != ROOT);
      unlinked = (next_rd == n_ff) && (prev_rd == n_ff);
      in_list  = (next_rd != n_ff) && (prev_rd != n_ff);
      case (mode_ff)
         MODE_ADD_HEAD:  applied_in = not_root && (prev_rd != ROOT) && unlinked;
         MODE_ADD_TAIL:  applied_in = not_root && (next_rd != ROOT) && unlinked;
         MODE_MOVE_HEAD: applied_in = not_root && (prev_rd != ROOT) && in_list
                                      && (next_rd != prev_rd);
         MODE_MOVE_TAIL: applied_in = not_root && (next_rd != ROOT) && in_list
                                      && (next_rd != prev_rd);
         MODE_REMOVE:    applied_in = not_root && in_list;
         default:        applied_in = 1'b0;
      endcase
      applied_in = applied_in && in_range_ff && phase.evaluating;
      linked_in  = in_range_ff && (next_rd != n_ff);
      // The neighbor at the chosen end, before this item changes anything.
      if ((mode_ff == MODE_ADD_HEAD) || (mode_ff == MODE_MOVE_HEAD)) begin
         e_in = head_ff;
      end else begin
         e_in = tail_ff;
      end
   end

   // Write steps: unlink first (moves, remove), then splice in at the end (adds, moves) or self-link (remove).
   always_comb begin
      nw_en   = 1'b0;
      nw_addr = n_ff;
      nw_data = n_ff;
      pw_en   = 1'b0;
      pw_addr = n_ff;
      pw_data = n_ff;
      if (phase.clearing) begin
         nw_en   = 1'b1;
         nw_addr = clr_ff;
         nw_data = clr_ff;
         pw_en   = 1'b1;
         pw_addr = clr_ff;
         pw_data = clr_ff;
      end else if (phase.writing) begin
         case (mode_ff)
            MODE_ADD_HEAD: begin
               case (phase.slot)
                  2'd0: begin
                     nw_en = 1'b1; nw_addr = n_ff; nw_data = e_ff;
                     pw_en = 1'b1; pw_addr = e_ff; pw_data = n_ff;
                  end
                  2'd1: begin
                     nw_en = 1'b1; nw_addr = ROOT; nw_data = n_ff;
                     pw_en = 1'b1; pw_addr = n_ff; pw_data = ROOT;
                  end
                  default: ;
               endcase
            end
            MODE_ADD_TAIL: begin
               case (phase.slot)
                  2'd0: begin
                     nw_en = 1'b1; nw_addr = n_ff; nw_data = ROOT;
                     pw_en = 1'b1; pw_addr = ROOT; pw_data = n_ff;
                  end
                  2'd1: begin
                     nw_en = 1'b1; nw_addr = e_ff; nw_data = n_ff;
                     pw_en = 1'b1; pw_addr = n_ff; pw_data = e_ff;
                  end
                  default: ;
               endcase
            end
            MODE_MOVE_HEAD: begin
               case (phase.slot)
                  2'd0: begin
                     nw_en = 1'b1; nw_addr = p_ff; nw_data = x_ff;
                     pw_en = 1'b1; pw_addr = x_ff; pw_data = p_ff;
                  end
                  2'd1: begin
                     nw_en = 1'b1; nw_addr = n_ff; nw_data = e_ff;
                     pw_en = 1'b1; pw_addr = e_ff; pw_data = n_ff;
                  end
                  default: begin
                     nw_en = 1'b1; nw_addr = ROOT; nw_data = n_ff;
                     pw_en = 1'b1; pw_addr = n_ff; pw_data = ROOT;
                  end
               endcase
            end
            MODE_MOVE_TAIL: begin
               case (phase.slot)
                  2'd0: begin
                     nw_en = 1'b1; nw_addr = p_ff; nw_data = x_ff;
                     pw_en = 1'b1; pw_addr = x_ff; pw_data = p_ff;
                  end
                  2'd1: begin
                     nw_en = 1'b1; nw_addr = n_ff; nw_data = ROOT;
                     pw_en = 1'b1; pw_addr = ROOT; pw_data = n_ff;
                  end
                  default: begin
                     nw_en = 1'b1; nw_addr = e_ff; nw_data = n_ff;
                     pw_en = 1'b1; pw_addr = n_ff; pw_data = e_ff;
                  end
               endcase
            end
            MODE_REMOVE: begin
               case (phase.slot)
                  2'd0: begin
                     nw_en = 1'b1; nw_addr = p_ff; nw_data = x_ff;
                     pw_en = 1'b1; pw_addr = x_ff; pw_data = p_ff;
                  end
                  2'd1: begin
                     nw_en = 1'b1; nw_addr = n_ff; nw_data = n_ff;
                     pw_en = 1'b1; pw_addr = n_ff; pw_data = n_ff;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // Clearing counter and copies of the root entry's links.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         head_ff <= ROOT;
         tail_ff <= ROOT;
      end else begin
         if (phase.clearing) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (nw_en && (nw_addr == ROOT)) begin
            head_ff <= nw_data;
         end
         if (pw_en && (pw_addr == ROOT)) begin
            tail_ff <= pw_data;
         end
      end
   end

   // Item capture and the entry's neighbors.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= req_mode;
         n_ff        <= LINK_W'(req_entry_index);
         in_range_ff <= (32'(req_entry_index) < 32'(ENTRIES));
      end
      if (phase.evaluating) begin
         p_ff       <= prev_rd;
         x_ff       <= next_rd;
         e_ff       <= e_in;
         applied_ff <= applied_in;
         linked_ff  <= linked_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (phase.finishing && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (phase.finishing && rsp_free) begin
         rsp_applied_ff      <= applied_ff;
         rsp_was_linked_ff   <= linked_ff;
         rsp_list_empty_ff   <= (head_ff == ROOT);
         rsp_most_recent_ff  <= INDEX_W'(head_ff);
         rsp_least_recent_ff <= INDEX_W'(tail_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_applied      = rsp_applied_ff;
   assign rsp_was_linked   = rsp_was_linked_ff;
   assign rsp_list_empty   = rsp_list_empty_ff;
   assign rsp_most_recent  = rsp_most_recent_ff;
   assign rsp_least_recent = rsp_least_recent_ff;

endmodule

>>> src/lruilm_ram.sv
module lruilm_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/lruilm_seq.sv
module lruilm_seq
   import lruilm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      clear_last,
   input  logic      apply,
   input  logic      rsp_free,
   output logic      req_stall,
   output phase_type phase
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_WR0   = 3'd3;
   localparam logic [2:0] S_WR1   = 3'd4;
   localparam logic [2:0] S_WR2   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state: clear pass, then one item at a time through up to three write steps.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clear_last) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_EVAL;
         S_EVAL:  state_in = apply ? S_WR0 : S_DONE;
         S_WR0:   state_in = S_WR1;
         S_WR1:   state_in = S_WR2;
         S_WR2:   state_in = S_DONE;
         S_DONE:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Phase decode for the datapath.
   always_comb begin
      phase.clearing   = (state_ff == S_CLEAR);
      phase.evaluating = (state_ff == S_EVAL);
      phase.writing    = (state_ff == S_WR0) || (state_ff == S_WR1) || (state_ff == S_WR2);
      phase.finishing  = (state_ff == S_DONE);
      case (state_ff)
         S_WR1:   phase.slot = 2'd1;
         S_WR2:   phase.slot = 2'd2;
         default: phase.slot = 2'd0;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

>>> src/lruilm_check.sv
module lruilm_check
   import lruilm_pkg::*;
#(
   parameter int ROOT_INDEX = LRUILM_ROOT_INDEX
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_applied,
   input logic               rsp_was_linked,
   input logic               rsp_list_empty,
   input logic [INDEX_W-1:0] rsp_most_recent,
   input logic [INDEX_W-1:0] rsp_least_recent
);

   localparam logic [INDEX_W-1:0] ROOT_LOW = INDEX_W'(ROOT_INDEX);

   // A result held by the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_most_recent)
         && $stable(rsp_least_recent) && $stable(rsp_applied))
      else $error("held result changed");

   // An empty list has the root at both ends.
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_empty |->
         (rsp_most_recent == ROOT_LOW) && (rsp_least_recent == ROOT_LOW))
      else $error("empty list with a member at an end");

   // An applied add always leaves at least one member.
   a_add_fills: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_applied && !rsp_was_linked |-> !rsp_list_empty)
      else $error("applied add left the list empty");

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while busy");

   // No result right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind lru_index_list_manager lruilm_check #(.ROOT_INDEX(ROOT_INDEX)) u_check (.*);

>>> tb/lru_list_check_pkg.sv
package lru_list_check_pkg;
   import lruilm_pkg::*;

   // Mode codes the block does not define; an item carrying one is ignored.
   localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

   localparam logic [INDEX_W-1:0] ROOT_ENTRY = INDEX_W'(LRUILM_ROOT_INDEX);

   // One result item as the block reports it.
   typedef struct packed {
      logic               applied;
      logic               was_linked;
      logic               list_empty;
      logic [INDEX_W-1:0] most_recent;
      logic [INDEX_W-1:0] least_recent;
   } list_outcome_type;

   // Tracks the recency list and holds the outcomes still owed by the block.
   class recency_list_model;
      logic [INDEX_W-1:0] next_link [LRUILM_ENTRIES];
      logic [INDEX_W-1:0] prev_link [LRUILM_ENTRIES];
      list_outcome_type   owed_outcomes [$];
      int unsigned        mismatch_count;

      // After reset every entry, the root too, links to itself.
      function new();
         for (int i = 0; i < LRUILM_ENTRIES; i++) begin
            next_link[i] = i[INDEX_W-1:0];
            prev_link[i] = i[INDEX_W-1:0];
         end
         mismatch_count = 0;
      endfunction

      // Takes an entry out of the list and makes it point to itself.
      function void unlink(logic [INDEX_W-1:0] n);
         logic [INDEX_W-1:0] p;
         logic [INDEX_W-1:0] x;
         p = prev_link[n];
         x = next_link[n];
         prev_link[x] = p;
         next_link[p] = x;
         next_link[n] = n;
         prev_link[n] = n;
      endfunction

      // Splices an entry in between two neighbors.
      function void splice(logic [INDEX_W-1:0] n, logic [INDEX_W-1:0] p,
                           logic [INDEX_W-1:0] x);
         prev_link[x] = n;
         next_link[n] = x;
         prev_link[n] = p;
         next_link[p] = n;
      endfunction

      // Applies one accepted item to the list and records what it must report.
      function void note_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] n);
         logic [INDEX_W-1:0] nx;
         logic [INDEX_W-1:0] pv;
         logic               not_root;
         logic               unlinked;
         logic               in_list;
         list_outcome_type   outcome;
         nx       = next_link[n];
         pv       = prev_link[n];
         not_root = (n != ROOT_ENTRY);
         unlinked = (nx == n) && (pv == n);
         in_list  = (nx != n) && (pv != n);
         outcome  = '0;
         outcome.was_linked = (nx != n);
         case (mode)
            MODE_ADD_HEAD: begin
               if (not_root && pv != ROOT_ENTRY && unlinked) begin
                  splice(n, ROOT_ENTRY, next_link[ROOT_ENTRY]);
                  outcome.applied = 1'b1;
               end
            end
            MODE_ADD_TAIL: begin
               if (not_root && nx != ROOT_ENTRY && unlinked) begin
                  splice(n, prev_link[ROOT_ENTRY], ROOT_ENTRY);
                  outcome.applied = 1'b1;
               end
            end
            MODE_MOVE_HEAD: begin
               if (not_root && pv != ROOT_ENTRY && in_list && nx != pv) begin
                  unlink(n);
                  splice(n, ROOT_ENTRY, next_link[ROOT_ENTRY]);
                  outcome.applied = 1'b1;
               end
            end
            MODE_MOVE_TAIL: begin
               if (not_root && nx != ROOT_ENTRY && in_list && nx != pv) begin
                  unlink(n);
                  splice(n, prev_link[ROOT_ENTRY], ROOT_ENTRY);
                  outcome.applied = 1'b1;
               end
            end
            MODE_REMOVE: begin
               if (not_root && in_list) begin
                  unlink(n);
                  outcome.applied = 1'b1;
               end
            end
            default: begin
            end
         endcase
         outcome.list_empty   = (next_link[ROOT_ENTRY] == ROOT_ENTRY);
         outcome.most_recent  = next_link[ROOT_ENTRY];
         outcome.least_recent = prev_link[ROOT_ENTRY];
         owed_outcomes.push_back(outcome);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
         end
      endfunction

      // Compares one accepted result item with the oldest owed outcome.
      function void check_outcome(list_outcome_type got);
         list_outcome_type want;
         if (owed_outcomes.size() == 0) begin
            $error("result item arrived with no outcome owed");
            mismatch_count++;
            return;
         end
         want = owed_outcomes.pop_front();
         compare_field("applied", want.applied, got.applied);
         compare_field("was_linked", want.was_linked, got.was_linked);
         compare_field("list_empty", want.list_empty, got.list_empty);
         compare_field("most_recent", want.most_recent, got.most_recent);
         compare_field("least_recent", want.least_recent, got.least_recent);
      endfunction
   endclass

endpackage

>>> tb/lru_index_list_manager_test.sv
module lru_index_list_manager_test;
   import lruilm_pkg::*;
   import lru_list_check_pkg::*;

   localparam int QUIET_LIMIT  = 5000;
   localparam int RANDOM_ITEMS = 1880;
   localparam int LONG_HOLD    = 200;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [MODE_W-1:0]  req_mode;
   logic [INDEX_W-1:0] req_entry_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_applied;
   logic               rsp_was_linked;
   logic               rsp_list_empty;
   logic [INDEX_W-1:0] rsp_most_recent;
   logic [INDEX_W-1:0] rsp_least_recent;

   recency_list_model lru_model;
   bit                send_idles;
   bit                take_idles;
   bit                hold_due;
   int                quiet_cycles;
   int unsigned       window_base;
   int unsigned       window_span;

   lru_index_list_manager u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_applied      (rsp_applied),
      .rsp_was_linked   (rsp_was_linked),
      .rsp_list_empty   (rsp_list_empty),
      .rsp_most_recent  (rsp_most_recent),
      .rsp_least_recent (rsp_least_recent)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Ends the run if neither channel moves an item for too long.
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL lru_index_list_manager");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one item after an optional gap and waits until it is taken.
   task automatic send_op(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] index);
      int gap;
      gap = send_idles ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_index <= index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lru_model.note_request(mode, index);
   endtask

   // Takes result items, stalling for a drawn number of cycles before each one.
   task automatic take_results();
      int               gap;
      list_outcome_type got;
      forever begin
         gap = take_idles ? $urandom_range(0, 6) : 0;
         if (hold_due) begin
            hold_due = 1'b0;
            gap      = LONG_HOLD;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.applied      = rsp_applied;
         got.was_linked   = rsp_was_linked;
         got.list_empty   = rsp_list_empty;
         got.most_recent  = rsp_most_recent;
         got.least_recent = rsp_least_recent;
         lru_model.check_outcome(got);
      end
   endtask

   // Mostly entries of a small window, so that lists grow and shrink;
   // sometimes the root or any entry of the pool.
   function automatic logic [INDEX_W-1:0] pick_entry();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return ROOT_ENTRY;
      if (roll < 16) return INDEX_W'($urandom_range(0, LRUILM_ENTRIES - 1));
      return INDEX_W'(window_base + $urandom_range(0, window_span - 1));
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      if ($urandom_range(0, 99) < 6) begin
         return MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      end
      return MODE_W'($urandom_range(MODE_ADD_HEAD, MODE_REMOVE));
   endfunction

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_ADD_HEAD;
      req_entry_index <= '0;
      send_idles  = 1'b1;
      take_idles  = 1'b1;
      hold_due    = 1'b0;
      window_base = 1;
      window_span = 12;
      lru_model   = new();
      fork
         take_results();
      join_none
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored operations on an empty list and on the root.
      send_op(MODE_REMOVE, 10'd5);
      send_op(MODE_MOVE_HEAD, 10'd5);
      send_op(MODE_ADD_HEAD, ROOT_ENTRY);
      // A single member cannot be moved.
      send_op(MODE_ADD_HEAD, 10'd1);
      send_op(MODE_MOVE_HEAD, 10'd1);
      send_op(MODE_MOVE_TAIL, 10'd1);
      // Two members: adding twice is ignored, moves to either end apply once.
      send_op(MODE_ADD_TAIL, 10'd1023);
      send_op(MODE_ADD_HEAD, 10'd1023);
      send_op(MODE_MOVE_HEAD, 10'd1023);
      send_op(MODE_MOVE_HEAD, 10'd1023);
      send_op(MODE_MOVE_TAIL, 10'd1023);
      send_op(MODE_MOVE_TAIL, 10'd1023);
      // Longer list with alternating bit patterns in the index.
      send_op(MODE_ADD_HEAD, 10'd512);
      send_op(MODE_ADD_TAIL, 10'd341);
      send_op(MODE_ADD_HEAD, 10'd682);
      send_op(MODE_MOVE_TAIL, 10'd1);
      send_op(MODE_MOVE_HEAD, 10'd1);
      // Unused modes on a linked entry, an unlinked one and the root.
      send_op(MODE_SPARE_FIRST, 10'd1);
      send_op(MODE_SPARE_FIRST + 3'd1, 10'd2);
      send_op(MODE_SPARE_LAST, ROOT_ENTRY);
      send_op(MODE_REMOVE, ROOT_ENTRY);
      // Empty the list again.
      send_op(MODE_REMOVE, 10'd682);
      send_op(MODE_REMOVE, 10'd1);
      send_op(MODE_REMOVE, 10'd1023);
      send_op(MODE_REMOVE, 10'd341);
      send_op(MODE_REMOVE, 10'd512);

      // Random items; the window moves and idling changes every so often.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 120 == 0) begin
            window_span = $urandom_range(2, 16);
            window_base = $urandom_range(1, LRUILM_ENTRIES - 17);
            send_idles  = ($urandom_range(0, 3) != 0);
            take_idles  = ($urandom_range(0, 3) != 0);
         end
         // The receiver holds off for a long stretch while items keep coming.
         if (i == 300) hold_due = 1'b1;
         send_op(pick_mode(), pick_entry());
      end
      req_valid <= 1'b0;

      // Drain, then allow time for any stray result item.
      while (lru_model.owed_outcomes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (lru_model.mismatch_count == 0 && lru_model.owed_outcomes.size() == 0) begin
         $display("PASS lru_index_list_manager");
      end else begin
         $display("FAIL lru_index_list_manager");
      end
      $finish;
   end

endmodule

>>> sim.f
src/lruilm_pkg.sv
src/lruilm_ram.sv
src/lruilm_seq.sv
src/lru_index_list_manager.sv
src/lruilm_check.sv
tb/lru_list_check_pkg.sv
tb/lru_index_list_manager_test.sv
